FILE: hdl/ctbo_pkg.sv
// ctbo_pkg: shared types and codes for the text cursor blink overlay.
// No dependencies; used by ctbo_hit, the top level and the bench.
package ctbo_pkg;

   // command codes carried in cmd
   localparam logic [1:0] CMD_PIXEL      = 2'd0;
   localparam logic [1:0] CMD_TICK       = 2'd1;
   localparam logic [1:0] CMD_SET_CURSOR = 2'd2;
   localparam logic [1:0] CMD_SPARE      = 2'd3;   // unused, swallowed

   // cursor kinds; the spare code draws as a block
   localparam logic [1:0] KIND_NONE       = 2'd0;
   localparam logic [1:0] KIND_UNDERSCORE = 2'd1;
   localparam logic [1:0] KIND_BLOCK      = 2'd2;
   localparam logic [1:0] KIND_SPARE      = 2'd3;

   // register indexes on the csr port
   localparam logic [1:0] REG_CELL_WIDTH   = 2'd0;
   localparam logic [1:0] REG_CELL_HEIGHT  = 2'd1;
   localparam logic [1:0] REG_COLUMN_COUNT = 2'd2;

   localparam int CsrIndexBits = 2;
   localparam int CsrDataBits  = 7;

   localparam logic [3:0] CELL_WIDTH_RESET   = 4'd4;
   localparam logic [5:0] CELL_HEIGHT_RESET  = 6'd16;
   localparam logic [6:0] COLUMN_COUNT_RESET = 7'd40;

   typedef struct packed {
      logic [3:0] cell_width_words;
      logic [5:0] cell_height;
      logic [6:0] column_count;
   } cfg_type;

   typedef struct packed {
      logic [7:0] col;
      logic [7:0] row;
      logic [1:0] kind;
      logic       blink_on;
   } cursor_type;

   // one input item as held in the input register
   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] word_in;
      logic [4:0]  scan_index;
      logic [7:0]  word_index;
      logic [5:0]  wobble_offset;
      logic [5:0]  text_row;
      logic [4:0]  glyph_row_start;
      logic [7:0]  cursor_col;
      logic [7:0]  cursor_row;
      logic [1:0]  cursor_kind;
   } req_item_type;

endpackage

FILE: hdl/ctbo_if.sv
// ctbo_req_if / ctbo_rsp_if: valid/ready channels of the cursor overlay.
// No dependencies.
interface ctbo_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [31:0] word_in;
   logic [4:0]  scan_index;
   logic [7:0]  word_index;
   logic signed [5:0] wobble_offset;
   logic [5:0]  text_row;
   logic [4:0]  glyph_row_start;
   logic signed [7:0] cursor_col;
   logic signed [7:0] cursor_row;
   logic [1:0]  cursor_kind;

   modport source (output valid, cmd, word_in, scan_index, word_index, wobble_offset,
                   text_row, glyph_row_start, cursor_col, cursor_row, cursor_kind,
                   input ready);
   modport sink (input valid, cmd, word_in, scan_index, word_index, wobble_offset,
                 text_row, glyph_row_start, cursor_col, cursor_row, cursor_kind,
                 output ready);
endinterface

interface ctbo_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] word_out;
   logic        inverted;

   modport source (output valid, word_out, inverted, input ready);
   modport sink (input valid, word_out, inverted, output ready);
endinterface

FILE: hdl/ctbo_hit.sv
// ctbo_hit: decides whether a pixel word lies inside the visible cursor cell.
// Depends on ctbo_pkg.
module ctbo_hit #(
   parameter int LINE_WORDS = 160
) (
   input  ctbo_pkg::req_item_type item,
   input  ctbo_pkg::cursor_type   cursor,
   input  ctbo_pkg::cfg_type      cfg,
   output logic                   hit
);

   logic               kind_ok;
   logic               col_ok;
   logic               row_ok;
   logic               scan_ok;
   logic               word_ok;
   logic signed [7:0]  first_line;
   logic [10:0]        col_base;
   logic signed [12:0] wob_ext;
   logic signed [12:0] w0;
   logic signed [12:0] w1;
   logic signed [12:0] word_s;

   assign kind_ok = (cursor.kind != ctbo_pkg::KIND_NONE) && cursor.blink_on;
   assign col_ok  = !cursor.col[7] && (cursor.col < {1'b0, cfg.column_count});
   assign row_ok  = cursor.row == {2'b00, item.text_row};

   // underscore covers the last two glyph rows; band start shifts it up
   assign first_line = $signed({2'b00, cfg.cell_height}) - 8'sd2
                       - $signed({3'b000, item.glyph_row_start});
   assign scan_ok = (cursor.kind != ctbo_pkg::KIND_UNDERSCORE)
                    || ($signed({3'b000, item.scan_index}) >= first_line);

   assign col_base = {4'b0000, cursor.col[6:0]} * {7'b000_0000, cfg.cell_width_words};
   assign wob_ext  = {{7{item.wobble_offset[5]}}, item.wobble_offset};
   assign w0       = $signed({2'b00, col_base}) + wob_ext;
   assign w1       = w0 + $signed({9'b0_0000_0000, cfg.cell_width_words});
   assign word_s   = $signed({5'b0_0000, item.word_index});

   // left clip is implicit (word index is never negative)
   assign word_ok = (word_s >= w0) && (word_s < w1)
                    && ({1'b0, item.word_index} < 9'(LINE_WORDS));

   assign hit = kind_ok && col_ok && row_ok && scan_ok && word_ok;

endmodule

FILE: hdl/text_cursor_blink_overlay_unit.sv
// text_cursor_blink_overlay_unit: cursor overlay on streamed text scanlines.
// Stages: input register, then result register; a pixel word's result is registered
// as it leaves the input register. Frame ticks and set-cursor items give no result.
// Throughput: one item per cycle unless a pixel word waits for the result stage.
// Reset (synchronous, active high) empties both stages, restores the cell
// registers to 4/16/40, clears the cursor and starts the blink visible.
module text_cursor_blink_overlay_unit #(
   parameter int BLINK_FRAMES = 15,
   parameter int LINE_WORDS   = 160
) (
   input  logic                               clock,
   input  logic                               reset,
   ctbo_req_if.sink                           req_chan,
   ctbo_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  logic [ctbo_pkg::CsrIndexBits-1:0]  csr_index,
   input  logic [ctbo_pkg::CsrDataBits-1:0]   csr_wdata
);

   // input register
   logic                   s1_valid_ff;
   ctbo_pkg::req_item_type s1_item_ff;
   ctbo_pkg::req_item_type s1_item_in;

   // result register
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [31:0] rsp_word_ff;
   logic [31:0] rsp_word_in;
   logic        rsp_inv_ff;

   // cursor and blink state, cell geometry
   ctbo_pkg::cursor_type cursor_ff;
   ctbo_pkg::cursor_type cursor_in;
   logic [3:0]           ticks_ff;
   logic [3:0]           ticks_in;
   logic [3:0]           ticks_inc;
   ctbo_pkg::cfg_type    cfg_ff;

   logic out_free;
   logic s1_fire;
   logic s1_pixel;
   logic req_take;
   logic hit;
   logic moved;

   // The result stage frees when empty or drained this cycle. Items that
   // give no result leave the input register regardless of the output side.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign s1_pixel = s1_item_ff.cmd == ctbo_pkg::CMD_PIXEL;
   assign s1_fire  = s1_valid_ff && (!s1_pixel || out_free);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !s1_valid_ff || s1_fire;

   assign s1_item_in = '{cmd:             req_chan.cmd,
                         word_in:         req_chan.word_in,
                         scan_index:      req_chan.scan_index,
                         word_index:      req_chan.word_index,
                         wobble_offset:   req_chan.wobble_offset,
                         text_row:        req_chan.text_row,
                         glyph_row_start: req_chan.glyph_row_start,
                         cursor_col:      req_chan.cursor_col,
                         cursor_row:      req_chan.cursor_row,
                         cursor_kind:     req_chan.cursor_kind};

   ctbo_hit #(
      .LINE_WORDS (LINE_WORDS)
   ) u_hit (
      .item   (s1_item_ff),
      .cursor (cursor_ff),
      .cfg    (cfg_ff),
      .hit    (hit)
   );

   assign rsp_word_in = s1_item_ff.word_in ^ {32{hit}};

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (s1_fire && s1_pixel) begin
         rsp_valid_in = 1'b1;
      end
   end

   // State changes happen as the item leaves the input register, so pixel
   // words always see the state left by the items ahead of them.
   assign ticks_inc = ticks_ff + 4'd1;
   assign moved = (s1_item_ff.cursor_col != cursor_ff.col)
                  || (s1_item_ff.cursor_row != cursor_ff.row);

   always_comb begin
      cursor_in = cursor_ff;
      ticks_in  = ticks_ff;
      if (s1_fire) begin
         case (s1_item_ff.cmd)
            ctbo_pkg::CMD_TICK: begin
               ticks_in = ticks_inc;
               if (ticks_inc >= 4'(BLINK_FRAMES)) begin
                  ticks_in           = 4'd0;
                  cursor_in.blink_on = !cursor_ff.blink_on;
               end
            end
            ctbo_pkg::CMD_SET_CURSOR: begin
               // same position keeps the blink phase
               if (moved) begin
                  ticks_in           = 4'd0;
                  cursor_in.blink_on = 1'b1;
               end
               cursor_in.col  = s1_item_ff.cursor_col;
               cursor_in.row  = s1_item_ff.cursor_row;
               cursor_in.kind = s1_item_ff.cursor_kind;
            end
            default: begin
               // pixel words and the spare code leave state alone
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cursor_ff    <= '{col: 8'd0, row: 8'd0, kind: ctbo_pkg::KIND_NONE,
                           blink_on: 1'b1};
         ticks_ff     <= 4'd0;
         cfg_ff       <= '{cell_width_words: ctbo_pkg::CELL_WIDTH_RESET,
                           cell_height:      ctbo_pkg::CELL_HEIGHT_RESET,
                           column_count:     ctbo_pkg::COLUMN_COUNT_RESET};
      end else begin
         if (req_chan.ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         rsp_valid_ff <= rsp_valid_in;
         cursor_ff    <= cursor_in;
         ticks_ff     <= ticks_in;
         if (csr_we) begin
            case (csr_index)
               ctbo_pkg::REG_CELL_WIDTH:   cfg_ff.cell_width_words <= csr_wdata[3:0];
               ctbo_pkg::REG_CELL_HEIGHT:  cfg_ff.cell_height      <= csr_wdata[5:0];
               ctbo_pkg::REG_COLUMN_COUNT: cfg_ff.column_count     <= csr_wdata[6:0];
               default: begin
                  // unmapped index: write dropped
               end
            endcase
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= s1_item_in;
      end
      if (s1_fire && s1_pixel) begin
         rsp_word_ff <= rsp_word_in;
         rsp_inv_ff  <= hit;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.word_out = rsp_word_ff;
   assign rsp_chan.inverted = rsp_inv_ff;

endmodule

FILE: dv/tb_text_cursor_blink_overlay_unit.sv
// tb_text_cursor_blink_overlay_unit: self-checking bench for the text cursor overlay.
// Uses ctbo_pkg, the ctbo_req_if/ctbo_rsp_if channels and text_cursor_blink_overlay_unit.
// A directed table, then random items under several cell settings and idling mixes.
module tb_text_cursor_blink_overlay_unit;

   localparam int BLINK_FRAMES = 15;
   localparam int LINE_WORDS   = 160;
   localparam int PHASE_ITEMS  = 190;      // counted items per random phase
   localparam int N_PHASES     = 8;        // six fixed cell settings, two random
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DUT_LATENCY  = 2;

   // one pixel word as it should leave the block
   typedef struct packed {
      logic [31:0] word;
      logic        inv;
   } overlay_word_type;

   // a row of the directed table; pinned rows carry their result typed in
   typedef struct {
      ctbo_pkg::req_item_type item;
      bit           pinned;
      logic [31:0]  pinned_word;
      logic         pinned_inv;
   } stim_row_type;

   logic clock;
   logic reset;
   logic                              csr_we;
   logic [ctbo_pkg::CsrIndexBits-1:0] csr_index;
   logic [ctbo_pkg::CsrDataBits-1:0]  csr_wdata;

   ctbo_req_if req_bus ();
   ctbo_rsp_if rsp_bus ();

   text_cursor_blink_overlay_unit #(
      .BLINK_FRAMES (BLINK_FRAMES),
      .LINE_WORDS   (LINE_WORDS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------
   // Predictor state: cell geometry, cursor and blink phase
   // ---------------------------------------------------------------
   ctbo_pkg::cfg_type cell_cfg = '{ctbo_pkg::CELL_WIDTH_RESET, ctbo_pkg::CELL_HEIGHT_RESET,
                                   ctbo_pkg::COLUMN_COUNT_RESET};
   logic signed [7:0] pos_col = '0;
   logic signed [7:0] pos_row = '0;
   logic [1:0]        shape = ctbo_pkg::KIND_NONE;
   logic [3:0]        tick_count = '0;
   bit                cursor_visible = 1'b1;

   overlay_word_type  overlay_words_due[$];
   stim_row_type      stim_rows[$];

   // idling knobs, percent of cycles; set_pct is a percent of random items
   int sender_idle_pct = 0;
   int stall_pct = 0;
   int set_pct = 10;

   int fail_count = 0;
   int cycle_count = 0;
   int pixel_count = 0;
   int inverted_count = 0;
   int toggle_count = 0;
   int move_count = 0;
   int setting_count = 0;

   // fixed cell settings: reset values, lower extremes, upper extremes, odd mixes
   int setting_width[6]  = '{4, 0, 15, 1, 8, 3};
   int setting_height[6] = '{16, 2, 63, 0, 32, 9};
   int setting_cols[6]   = '{40, 1, 127, 80, 0, 20};

   // ---------------------------------------------------------------
   // Clock and cycle guard
   // ---------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("text_cursor_blink_overlay_unit test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------

   // does the visible cursor cell cover this pixel word?
   function automatic bit cursor_covers(ctbo_pkg::req_item_type it);
      int scan, word, wob, trow, first, w0, w1, cw;
      scan = int'(it.scan_index);
      word = int'(it.word_index);
      wob  = int'($signed(it.wobble_offset));
      trow = int'(it.text_row);
      cw   = int'(cell_cfg.cell_width_words);
      first = 0;
      if (shape == ctbo_pkg::KIND_NONE || !cursor_visible || int'(pos_row) != trow)
         return 1'b0;
      if (pos_col < 0 || int'(pos_col) >= int'(cell_cfg.column_count))
         return 1'b0;
      // underscore: last two glyph rows, clamped to the band's first line
      if (shape == ctbo_pkg::KIND_UNDERSCORE) begin
         first = int'(cell_cfg.cell_height) - 2 - int'(it.glyph_row_start);
         if (first < 0)
            first = 0;
      end
      if (scan < first)
         return 1'b0;
      w0 = wob + int'(pos_col) * cw;
      w1 = w0 + cw;
      if (w0 < 0)
         w0 = 0;
      if (w1 > LINE_WORDS)
         w1 = LINE_WORDS;
      return (word >= w0) && (word < w1);
   endfunction

   // advance the cursor state by one item; a pixel word yields one result
   function automatic bit predict_overlay(ctbo_pkg::req_item_type it,
                                          output overlay_word_type res);
      bit hit;
      res = '0;
      case (it.cmd)
         ctbo_pkg::CMD_PIXEL: begin
            hit = cursor_covers(it);
            res.word = hit ? ~it.word_in : it.word_in;
            res.inv  = hit;
            pixel_count++;
            if (hit)
               inverted_count++;
            return 1'b1;
         end
         ctbo_pkg::CMD_TICK: begin
            tick_count = tick_count + 4'd1;
            if (tick_count >= BLINK_FRAMES) begin
               tick_count = '0;
               cursor_visible = !cursor_visible;
               toggle_count++;
            end
         end
         ctbo_pkg::CMD_SET_CURSOR: begin
            // a move restarts the blink visible; same place keeps the phase
            if (it.cursor_col != pos_col || it.cursor_row != pos_row) begin
               tick_count = '0;
               cursor_visible = 1'b1;
               move_count++;
            end
            pos_col = it.cursor_col;
            pos_row = it.cursor_row;
            shape   = it.cursor_kind;
         end
         default: ;   // spare command: ignored
      endcase
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   task automatic add_row(input logic [1:0] cmd, input logic [31:0] word, input int scan,
                          input int widx, input int wob, input int trow, input int g0,
                          input int ccol, input int crow_new, input logic [1:0] kind,
                          input bit pinned = 1'b0, input logic [31:0] pw = '0,
                          input logic pi = 1'b0);
      stim_row_type r;
      r.item.cmd             = cmd;
      r.item.word_in         = word;
      r.item.scan_index      = 5'(scan);
      r.item.word_index      = 8'(widx);
      r.item.wobble_offset   = 6'(wob);
      r.item.text_row        = 6'(trow);
      r.item.glyph_row_start = 5'(g0);
      r.item.cursor_col      = 8'(ccol);
      r.item.cursor_row      = 8'(crow_new);
      r.item.cursor_kind     = kind;
      r.pinned      = pinned;
      r.pinned_word = pw;
      r.pinned_inv  = pi;
      stim_rows.push_back(r);
   endtask

   // random item, steered towards the cursor cell so that hits are common
   function automatic ctbo_pkg::req_item_type random_item();
      ctbo_pkg::req_item_type it;
      int pick, span, base, r;
      it.cmd             = ctbo_pkg::CMD_PIXEL;
      it.word_in         = $urandom();
      it.scan_index      = 5'($urandom_range(31));
      it.word_index      = 8'($urandom_range(255));
      it.wobble_offset   = ($urandom_range(1) != 0) ? 6'($urandom_range(63)) : '0;
      it.text_row        = 6'($urandom_range(63));
      it.glyph_row_start = 5'($urandom_range(31));
      it.cursor_col      = 8'($urandom_range(255));
      it.cursor_row      = 8'($urandom_range(255));
      it.cursor_kind     = 2'($urandom_range(3));
      pick = $urandom_range(99);
      if (pick < 97 - set_pct - 25) begin
         it.cmd = ctbo_pkg::CMD_PIXEL;
         if ($urandom_range(3) != 0)
            it.text_row = pos_row[5:0];
         if ($urandom_range(4) < 3) begin
            span = int'(cell_cfg.cell_width_words);
            base = int'($signed(it.wobble_offset)) + int'(pos_col) * span;
            it.word_index = 8'(base + int'($urandom_range(span + 1)) - 1);
         end
      end else if (pick < 97 - set_pct) begin
         it.cmd = ctbo_pkg::CMD_TICK;
      end else if (pick < 97) begin
         it.cmd = ctbo_pkg::CMD_SET_CURSOR;
         r = $urandom_range(9);
         if (r < 4) begin
            // same place: only the kind changes
            it.cursor_col = pos_col;
            it.cursor_row = pos_row;
         end else if (r < 8) begin
            if (cell_cfg.column_count != 0)
               it.cursor_col = 8'($urandom_range(int'(cell_cfg.column_count) - 1));
            it.cursor_row = 8'($urandom_range(63));
         end
      end else begin
         it.cmd = ctbo_pkg::CMD_SPARE;   // must be swallowed
      end
      return it;
   endfunction

   // ---------------------------------------------------------------
   // Request side: called and returning at a falling edge
   // ---------------------------------------------------------------
   task automatic send_req(input ctbo_pkg::req_item_type it, input bit pinned = 1'b0,
                           input logic [31:0] pw = '0, input logic pi = 1'b0);
      overlay_word_type res;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.cmd             <= it.cmd;
      req_bus.word_in         <= it.word_in;
      req_bus.scan_index      <= it.scan_index;
      req_bus.word_index      <= it.word_index;
      req_bus.wobble_offset   <= it.wobble_offset;
      req_bus.text_row        <= it.text_row;
      req_bus.glyph_row_start <= it.glyph_row_start;
      req_bus.cursor_col      <= it.cursor_col;
      req_bus.cursor_row      <= it.cursor_row;
      req_bus.cursor_kind     <= it.cursor_kind;
      do
         @(posedge clock);
      while (!req_bus.ready);
      // item taken at this edge: work out its result now
      if (predict_overlay(it, res)) begin
         if (pinned) begin
            res.word = pw;
            res.inv  = pi;
         end
         overlay_words_due.push_back(res);
      end
      @(negedge clock);
   endtask

   // drop valid and wait for every outstanding pixel word, then extra spare cycles
   task automatic wait_quiet(input int extra);
      req_bus.valid <= 1'b0;
      do
         @(negedge clock);
      while (overlay_words_due.size() != 0);
      repeat (extra) @(negedge clock);
   endtask

   // write all three cell registers; block must be idle
   task automatic apply_cell_setting(input int cw, input int ch, input int cols);
      csr_we <= 1'b1;
      csr_index <= ctbo_pkg::REG_CELL_WIDTH;
      csr_wdata <= cw[ctbo_pkg::CsrDataBits-1:0];
      @(negedge clock);
      csr_index <= ctbo_pkg::REG_CELL_HEIGHT;
      csr_wdata <= ch[ctbo_pkg::CsrDataBits-1:0];
      @(negedge clock);
      csr_index <= ctbo_pkg::REG_COLUMN_COUNT;
      csr_wdata <= cols[ctbo_pkg::CsrDataBits-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
      cell_cfg.cell_width_words = 4'(cw);
      cell_cfg.cell_height      = 6'(ch);
      cell_cfg.column_count     = 7'(cols);
      setting_count++;
   endtask

   // ---------------------------------------------------------------
   // Result side: random back-pressure, checks at the rising edge
   // ---------------------------------------------------------------
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      overlay_word_type due;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (overlay_words_due.size() == 0) begin
            if (fail_count < 10)
               $display("ERROR: unexpected pixel word %h inverted %b",
                        rsp_bus.word_out, rsp_bus.inverted);
            fail_count++;
         end else begin
            due = overlay_words_due.pop_front();
            if (rsp_bus.word_out !== due.word) begin
               if (fail_count < 10)
                  $display("ERROR: word_out expected %h got %h", due.word, rsp_bus.word_out);
               fail_count++;
            end
            if (rsp_bus.inverted !== due.inv) begin
               if (fail_count < 10)
                  $display("ERROR: inverted expected %b got %b (word %h)",
                           due.inv, rsp_bus.inverted, due.word);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      int counted;
      int phase;
      int mode;
      ctbo_pkg::req_item_type it;

      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.cmd = ctbo_pkg::CMD_PIXEL;
      req_bus.word_in = '0;
      req_bus.scan_index = '0;
      req_bus.word_index = '0;
      req_bus.wobble_offset = '0;
      req_bus.text_row = '0;
      req_bus.glyph_row_start = '0;
      req_bus.cursor_col = '0;
      req_bus.cursor_row = '0;
      req_bus.cursor_kind = ctbo_pkg::KIND_NONE;

      // directed table, reset geometry 4/16/40
      // no cursor after reset
      add_row(ctbo_pkg::CMD_PIXEL, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, ctbo_pkg::KIND_NONE,
              1'b1, 32'hFFFF_FFFF, 1'b0);
      // spare command is ignored
      add_row(ctbo_pkg::CMD_SPARE, 32'hDEAD_BEEF, 31, 255, -1, 63, 31, -1, -1,
              ctbo_pkg::KIND_SPARE);
      // block cursor at home, same place so the blink stays visible
      add_row(ctbo_pkg::CMD_SET_CURSOR, '0, 0, 0, 0, 0, 0, 0, 0, ctbo_pkg::KIND_BLOCK);
      add_row(ctbo_pkg::CMD_PIXEL, 32'h1234_5678, 0, 0, 0, 0, 0, 0, 0, ctbo_pkg::KIND_NONE,
              1'b1, 32'hEDCB_A987, 1'b1);
      // last word of the cell, then first word past it
      add_row(ctbo_pkg::CMD_PIXEL, 32'h0000_0000, 5, 3, 0, 0, 0, 0, 0, ctbo_pkg::KIND_NONE,
              1'b1, 32'hFFFF_FFFF, 1'b1);
      add_row(ctbo_pkg::CMD_PIXEL, 32'h0000_0000, 5, 4, 0, 0, 0, 0, 0, ctbo_pkg::KIND_NONE,
              1'b1, 32'h0000_0000, 1'b0);
      // word beyond the line, and a different text row
      add_row(ctbo_pkg::CMD_PIXEL, 32'hA5A5_A5A5, 0, 255, 0, 0, 0, 0, 0, ctbo_pkg::KIND_NONE,
              1'b1, 32'hA5A5_A5A5, 1'b0);
      add_row(ctbo_pkg::CMD_PIXEL, 32'h0000_0000, 0, 0, 0, 63, 0, 0, 0, ctbo_pkg::KIND_NONE,
              1'b1, 32'h0000_0000, 1'b0);
      add_row(ctbo_pkg::CMD_TICK, '0, 0, 0, 0, 0, 0, 0, 0, ctbo_pkg::KIND_NONE);
      add_row(ctbo_pkg::CMD_TICK, '0, 0, 0, 0, 0, 0, 0, 0, ctbo_pkg::KIND_NONE);
      // underscore in the last column, cell touching the line end
      add_row(ctbo_pkg::CMD_SET_CURSOR, '0, 0, 0, 0, 0, 0, 39, 5, ctbo_pkg::KIND_UNDERSCORE);
      add_row(ctbo_pkg::CMD_PIXEL, 32'h0F0F_0F0F, 14, 156, 0, 5, 0, 0, 0, ctbo_pkg::KIND_NONE);
      add_row(ctbo_pkg::CMD_PIXEL, 32'h0F0F_0F0F, 13, 156, 0, 5, 0, 0, 0, ctbo_pkg::KIND_NONE);
      // wobble pushes the cell off the line end, then back left
      add_row(ctbo_pkg::CMD_PIXEL, 32'hFFFF_0000, 31, 159, 31, 5, 0, 0, 0, ctbo_pkg::KIND_NONE);
      add_row(ctbo_pkg::CMD_PIXEL, 32'h0000_FFFF, 20, 124, -32, 5, 0, 0, 0,
              ctbo_pkg::KIND_NONE);
      // negative column, spare kind
      add_row(ctbo_pkg::CMD_SET_CURSOR, '0, 0, 0, 0, 0, 0, -128, 5, ctbo_pkg::KIND_SPARE);
      add_row(ctbo_pkg::CMD_PIXEL, 32'h8000_0001, 31, 0, 0, 5, 0, 0, 0, ctbo_pkg::KIND_NONE);
      // column past the row, negative row
      add_row(ctbo_pkg::CMD_SET_CURSOR, '0, 0, 0, 0, 0, 0, 127, -128, ctbo_pkg::KIND_BLOCK);
      add_row(ctbo_pkg::CMD_PIXEL, 32'h7FFF_FFFE, 0, 0, 0, 0, 0, 0, 0, ctbo_pkg::KIND_NONE);
      // spare kind draws as a block; wobble moves the cell to start at word 0
      add_row(ctbo_pkg::CMD_SET_CURSOR, '0, 0, 0, 0, 0, 0, 2, 63, ctbo_pkg::KIND_SPARE);
      add_row(ctbo_pkg::CMD_PIXEL, 32'hFFFF_FFFF, 31, 0, -8, 63, 31, 0, 0,
              ctbo_pkg::KIND_NONE);
      // same place, kind change only
      add_row(ctbo_pkg::CMD_SET_CURSOR, '0, 0, 0, 0, 0, 0, 2, 63, ctbo_pkg::KIND_UNDERSCORE);
      // band starting late: underscore start clamped to the first line
      add_row(ctbo_pkg::CMD_PIXEL, 32'h5555_AAAA, 0, 3, -8, 63, 31, 0, 0, ctbo_pkg::KIND_NONE);
      add_row(ctbo_pkg::CMD_PIXEL, 32'h5555_AAAA, 0, 8, 0, 63, 0, 0, 0, ctbo_pkg::KIND_NONE);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      sender_idle_pct = 13;
      stall_pct = 13;
      foreach (stim_rows[i])
         send_req(stim_rows[i].item, stim_rows[i].pinned,
                  stim_rows[i].pinned_word, stim_rows[i].pinned_inv);

      for (phase = 0; phase < N_PHASES; phase++) begin
         // registers only change with the block drained
         wait_quiet(DUT_LATENCY + 2);
         if (phase < 6)
            apply_cell_setting(setting_width[phase], setting_height[phase],
                               setting_cols[phase]);
         else
            apply_cell_setting($urandom_range(15), $urandom_range(63), $urandom_range(127));
         // odd phases rarely move the cursor, so the blink gets to run
         set_pct = (phase % 2 == 0) ? 10 : 2;
         mode = phase % 4;
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            // an unthrottled stretch opens every phase
            if (counted < 40) begin
               sender_idle_pct = 0;
               stall_pct = 0;
            end else begin
               sender_idle_pct = (mode == 1) ? 78 : (mode == 3) ? 13 : 0;
               stall_pct       = (mode == 2) ? 78 : (mode == 3) ? 13 : 0;
            end
            // hold off mid phase until the pipe has emptied
            if (counted == PHASE_ITEMS / 2)
               wait_quiet(0);
            it = random_item();
            send_req(it);
            if (it.cmd != ctbo_pkg::CMD_SPARE)
               counted++;
         end
      end

      wait_quiet(DUT_LATENCY + 6);

      $display("Covered %0d pixel words (%0d inverted), %0d cursor moves, %0d blink toggles,",
               pixel_count, inverted_count, move_count, toggle_count);
      $display("over %0d cell settings and four idling mixes; %0d failures.",
               setting_count, fail_count);
      if (fail_count == 0 && overlay_words_due.size() == 0)
         $display("text_cursor_blink_overlay_unit test passed");
      else
         $display("text_cursor_blink_overlay_unit test failed");
      $finish;
   end

endmodule

FILE: text_cursor_blink_overlay_unit.f
hdl/ctbo_pkg.sv
hdl/ctbo_if.sv
hdl/ctbo_hit.sv
hdl/text_cursor_blink_overlay_unit.sv
dv/tb_text_cursor_blink_overlay_unit.sv
